/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assertion macros
// concurrent checks on the rising clock edge, empty under synthesis
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check with reset disable
`define CMDB_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check that also holds while reset is applied
`define CMDB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CMDB_ASSERT(lbl, clk, rstn, prop, msg)
`define CMDB_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

/* rtl/cmdb_pkg.sv */
// ----------------------------------------------------------------------------
// cmdb_pkg
// fixed-point formats, log2 polynomial coefficients and the horner step
// ----------------------------------------------------------------------------
package cmdb_pkg;

    localparam int QF        = 24;
    localparam int Y_BITS    = 28;
    localparam int PROD_BITS = Y_BITS + QF + 1;
    localparam int D_BITS    = 32;
    localparam int K_BITS    = 27;
    localparam int NORM_BITS = 17;
    localparam int NE_BITS   = 5;

    localparam logic [NORM_BITS-1:0] NORM_RESET = 17'd1024;

    // cubic in the mantissa, q24
    localparam logic signed [Y_BITS-1:0] POLY_C3 = 28'sd20661073;
    localparam logic signed [Y_BITS-1:0] POLY_C2 = -28'sd69097386;
    localparam logic signed [Y_BITS-1:0] POLY_C1 = 28'sd101031894;
    localparam logic signed [Y_BITS-1:0] POLY_C0 = -28'sd52579199;

    // 10*log10(2), q24
    localparam logic signed [K_BITS-1:0] DB_PER_LOG2 = 27'sd50504453;

    localparam logic signed [PROD_BITS-1:0] HORNER_RND_POS = PROD_BITS'(1) <<< (QF - 1);
    localparam logic signed [PROD_BITS-1:0] HORNER_RND_NEG = HORNER_RND_POS - PROD_BITS'(1);

    typedef logic signed [Y_BITS-1:0] poly_t;
    typedef logic signed [D_BITS-1:0] log_t;
    typedef logic [QF-1:0]            mant_t;

    // y*f rounded half away from zero back to q24, plus c
    function automatic poly_t horner_step(poly_t y, mant_t f, poly_t c);
        logic signed [PROD_BITS-1:0] prod;
        logic signed [PROD_BITS-1:0] rnd;
        prod = y * $signed({1'b0, f});
        rnd  = prod + (prod[PROD_BITS-1] ? HORNER_RND_NEG : HORNER_RND_POS);
        return poly_t'(rnd >>> QF) + c;
    endfunction

endpackage

/* rtl/cmdb_ifs.sv */
// ----------------------------------------------------------------------------
// cmdb channel interfaces
// valid/ready channels for samples, levels and the divisor write
// ----------------------------------------------------------------------------
interface cmdb_sample_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample_i;
    logic signed [SAMPLE_BITS-1:0] sample_q;

    modport source (output valid, output sample_i, output sample_q, input ready);
    modport sink   (input valid, input sample_i, input sample_q, output ready);
endinterface

interface cmdb_level_if #(
    parameter int LEVEL_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic signed [LEVEL_BITS-1:0] level_db;
    logic                         zero_input;

    modport source (output valid, output level_db, output zero_input, input ready);
    modport sink   (input valid, input level_db, input zero_input, output ready);
endinterface

interface cmdb_cfg_if #(
    parameter int NORM_BITS = 17
);
    logic                 valid;
    logic                 ready;
    logic [NORM_BITS-1:0] normalize_size;

    modport source (output valid, output normalize_size, input ready);
    modport sink   (input valid, input normalize_size, output ready);
endinterface

/* rtl/complex_magnitude_to_db_unit.sv */
// ----------------------------------------------------------------------------
// complex_magnitude_to_db_unit
// level of a complex sample as 20*log10(|x|/N) in dB, log2 by cubic
// polynomial on the normalized mantissa, saturated to +/-100 dB
// ----------------------------------------------------------------------------
//  channel  | dir | word
//  ---------+-----+-------------------------------------------
//  samples  | in  | sample_i, sample_q (SAMPLE_BITS, signed)
//  levels   | out | level_db (OUT_FRAC_BITS+8, signed), zero_input
//  cfg      | in  | normalize_size (17 bits), always ready
//
//  one word per cycle unless the pipeline holds; the leading-zero normalizer
//  takes one shift step per stage and is followed by three horner stages
//  reset clears valid bits and sets the divisor to 1024, no clearing pass
//  the divisor log runs free and settles after a write
//  a two-word output buffer lets the pipeline run while a word waits;
//  the pipeline holds only when both buffer words wait and the last stage is full
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module complex_magnitude_to_db_unit
    import cmdb_pkg::*;
#(
    parameter int SAMPLE_BITS   = 16,
    parameter int OUT_FRAC_BITS = 8
)(
    input  logic       clk,
    input  logic       rst_n,
    cmdb_sample_if.sink   samples,
    cmdb_level_if.source  levels,
    cmdb_cfg_if.sink      cfg
);

    localparam int M_BITS     = 2 * SAMPLE_BITS;
    localparam int NSTEP      = $clog2(M_BITS);
    localparam int LZ_BITS    = NSTEP;
    localparam int E_BITS     = $clog2(M_BITS + 1);
    localparam int LEVEL_BITS = OUT_FRAC_BITS + 8;
    localparam int MUL_BITS   = D_BITS + K_BITS;
    localparam int DB_SHIFT   = 2 * QF - OUT_FRAC_BITS;

    localparam int ST_H1  = 3 + NSTEP;
    localparam int ST_MUL = ST_H1 + 4;
    localparam int NUM_ST = ST_MUL + 1;

    localparam logic signed [MUL_BITS-1:0] DB_HALF    = MUL_BITS'(1) <<< (DB_SHIFT - 1);
    localparam logic signed [MUL_BITS-1:0] DB_HALF_M1 = DB_HALF - MUL_BITS'(1);
    localparam logic signed [MUL_BITS-1:0] DB_LIMIT   = MUL_BITS'(100) <<< OUT_FRAC_BITS;
    localparam logic signed [MUL_BITS-1:0] DB_LIMIT_N = -DB_LIMIT;

    localparam logic signed [LEVEL_BITS-1:0] LEVEL_MAX = LEVEL_BITS'(100 << OUT_FRAC_BITS);
    localparam logic signed [LEVEL_BITS-1:0] LEVEL_MIN = -LEVEL_MAX;

    // control
    logic [NUM_ST-1:0] valid_reg;
    logic              advance;
    logic              push;
    logic              pop;

    // divisor
    logic [NORM_BITS-1:0] normalize_size_reg;

    // free-running divisor log
    logic [NORM_BITS-1:0] n_eff;
    mant_t                nl_f_reg, nl_f_next;
    logic [NE_BITS-1:0]   nl_e_reg, nl_e_next;
    poly_t                nl_y1_reg, nl_y2_reg, nl_y3_reg;
    log_t                 nl_log2_reg, nl_log_n;

    // magnitude stages
    logic [SAMPLE_BITS-1:0] abs_i_reg, abs_i_next;
    logic [SAMPLE_BITS-1:0] abs_q_reg, abs_q_next;
    logic [M_BITS-1:0]      sq_i_reg, sq_i_next;
    logic [M_BITS-1:0]      sq_q_reg, sq_q_next;
    logic [M_BITS-1:0]      sum_reg, sum_next;
    logic                   sum_zero_reg, sum_zero_next;

    // normalizer
    logic [M_BITS-1:0]  norm_w_reg    [NSTEP];
    logic [LZ_BITS-1:0] norm_lz_reg   [NSTEP];
    logic               norm_zero_reg [NSTEP];
    mant_t              fm;
    logic [E_BITS-1:0]  em;

    // polynomial stages
    poly_t             h1_y_reg, h1_y_next, h2_y_reg, h2_y_next, h3_y_reg, h3_y_next;
    mant_t             h1_f_reg, h2_f_reg;
    logic [E_BITS-1:0] h1_e_reg, h2_e_reg, h3_e_reg;
    logic              h1_zero_reg, h2_zero_reg, h3_zero_reg;

    // difference and scale
    log_t                  log_m;
    log_t                  dif_reg, dif_next;
    logic                  dif_zero_reg;
    logic signed [MUL_BITS-1:0] mul_reg, mul_next;
    logic                  mul_zero_reg;
    logic signed [MUL_BITS-1:0] db_rnd, db_q;
    logic signed [LEVEL_BITS-1:0] level_word;

    // output buffer
    logic                         head_valid_reg, head_valid_next;
    logic                         tail_valid_reg, tail_valid_next;
    logic signed [LEVEL_BITS-1:0] head_level_reg, head_level_next;
    logic signed [LEVEL_BITS-1:0] tail_level_reg, tail_level_next;
    logic                         head_zero_reg, head_zero_next;
    logic                         tail_zero_reg, tail_zero_next;

    assign advance       = !(valid_reg[NUM_ST-1] && tail_valid_reg && !levels.ready);
    assign push          = advance && valid_reg[NUM_ST-1];
    assign pop           = head_valid_reg && levels.ready;
    assign samples.ready = advance;
    assign cfg.ready     = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[NUM_ST-2:0], samples.valid};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normalize_size_reg <= NORM_RESET;
        end
        else if (cfg.valid)
        begin
            normalize_size_reg <= cfg.normalize_size;
        end
    end

    // divisor log, zero taken as one
    always_comb
    begin
        n_eff     = (normalize_size_reg == '0) ? NORM_BITS'(1) : normalize_size_reg;
        nl_e_next = '0;
        for (int b = 0; b < NORM_BITS; b++)
        begin
            if (n_eff[b])
            begin
                nl_e_next = NE_BITS'(b + 1);
            end
        end
        nl_f_next = mant_t'(n_eff) << (NE_BITS'(QF) - nl_e_next);
        nl_log_n  = log_t'(nl_y3_reg) + $signed({{(D_BITS-NE_BITS-QF){1'b0}}, nl_e_reg,
                                                 {QF{1'b0}}});
    end

    always_ff @(posedge clk)
    begin
        nl_f_reg    <= nl_f_next;
        nl_e_reg    <= nl_e_next;
        nl_y1_reg   <= horner_step(POLY_C3, nl_f_reg, POLY_C2);
        nl_y2_reg   <= horner_step(nl_y1_reg, nl_f_reg, POLY_C1);
        nl_y3_reg   <= horner_step(nl_y2_reg, nl_f_reg, POLY_C0);
        nl_log2_reg <= nl_log_n <<< 1;
    end

    // abs, squares, sum
    always_comb
    begin
        abs_i_next    = samples.sample_i[SAMPLE_BITS-1] ? (~$unsigned(samples.sample_i) + 1'b1)
                                                        : $unsigned(samples.sample_i);
        abs_q_next    = samples.sample_q[SAMPLE_BITS-1] ? (~$unsigned(samples.sample_q) + 1'b1)
                                                        : $unsigned(samples.sample_q);
        sq_i_next     = abs_i_reg * abs_i_reg;
        sq_q_next     = abs_q_reg * abs_q_reg;
        sum_next      = sq_i_reg + sq_q_reg;
        sum_zero_next = (sum_next == '0);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            abs_i_reg    <= abs_i_next;
            abs_q_reg    <= abs_q_next;
            sq_i_reg     <= sq_i_next;
            sq_q_reg     <= sq_q_next;
            sum_reg      <= sum_next;
            sum_zero_reg <= sum_zero_next;
        end
    end

    // leading-zero normalizer, one shift step per stage
    for (genvar j = 0; j < NSTEP; j++)
    begin : g_norm
        localparam int SHIFT = 1 << (NSTEP - 1 - j);
        logic [M_BITS-1:0]  w_in, w_next;
        logic [LZ_BITS-1:0] lz_in, lz_next;
        logic               zero_in;

        if (j == 0)
        begin : g_first
            assign w_in    = sum_reg;
            assign lz_in   = '0;
            assign zero_in = sum_zero_reg;
        end
        else
        begin : g_later
            assign w_in    = norm_w_reg[j-1];
            assign lz_in   = norm_lz_reg[j-1];
            assign zero_in = norm_zero_reg[j-1];
        end

        always_comb
        begin
            w_next  = w_in;
            lz_next = lz_in;
            if (w_in[M_BITS-1 -: SHIFT] == '0)
            begin
                w_next  = w_in << SHIFT;
                lz_next = lz_in | LZ_BITS'(SHIFT);
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                norm_w_reg[j]    <= w_next;
                norm_lz_reg[j]   <= lz_next;
                norm_zero_reg[j] <= zero_in;
            end
        end
    end

    if (M_BITS >= QF)
    begin : g_mant_cut
        assign fm = norm_w_reg[NSTEP-1][M_BITS-1 -: QF];
    end
    else
    begin : g_mant_pad
        assign fm = {norm_w_reg[NSTEP-1], {(QF-M_BITS){1'b0}}};
    end

    assign em = E_BITS'(M_BITS) - E_BITS'(norm_lz_reg[NSTEP-1]);

    // horner stages, log difference, scale to dB
    always_comb
    begin
        h1_y_next = horner_step(POLY_C3, fm, POLY_C2);
        h2_y_next = horner_step(h1_y_reg, h1_f_reg, POLY_C1);
        h3_y_next = horner_step(h2_y_reg, h2_f_reg, POLY_C0);
        log_m     = log_t'(h3_y_reg) + $signed({{(D_BITS-E_BITS-QF){1'b0}}, h3_e_reg,
                                               {QF{1'b0}}});
        dif_next  = log_m - nl_log2_reg;
        mul_next  = dif_reg * DB_PER_LOG2;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            h1_y_reg     <= h1_y_next;
            h1_f_reg     <= fm;
            h1_e_reg     <= em;
            h1_zero_reg  <= norm_zero_reg[NSTEP-1];
            h2_y_reg     <= h2_y_next;
            h2_f_reg     <= h1_f_reg;
            h2_e_reg     <= h1_e_reg;
            h2_zero_reg  <= h1_zero_reg;
            h3_y_reg     <= h3_y_next;
            h3_e_reg     <= h2_e_reg;
            h3_zero_reg  <= h2_zero_reg;
            dif_reg      <= dif_next;
            dif_zero_reg <= h3_zero_reg;
            mul_reg      <= mul_next;
            mul_zero_reg <= dif_zero_reg;
        end
    end

    // round half away from zero, clamp, zero floor
    always_comb
    begin
        db_rnd = mul_reg + (mul_reg[MUL_BITS-1] ? DB_HALF_M1 : DB_HALF);
        db_q   = db_rnd >>> DB_SHIFT;
        if (mul_zero_reg)
        begin
            level_word = LEVEL_MIN;
        end
        else if (db_q > DB_LIMIT)
        begin
            level_word = LEVEL_MAX;
        end
        else if (db_q < DB_LIMIT_N)
        begin
            level_word = LEVEL_MIN;
        end
        else
        begin
            level_word = LEVEL_BITS'(db_q);
        end
    end

    // two-word output buffer
    always_comb
    begin
        head_valid_next = head_valid_reg;
        tail_valid_next = tail_valid_reg;
        head_level_next = head_level_reg;
        head_zero_next  = head_zero_reg;
        tail_level_next = tail_level_reg;
        tail_zero_next  = tail_zero_reg;
        if (pop)
        begin
            head_valid_next = tail_valid_reg || push;
            tail_valid_next = tail_valid_reg && push;
            head_level_next = tail_valid_reg ? tail_level_reg : level_word;
            head_zero_next  = tail_valid_reg ? tail_zero_reg : mul_zero_reg;
            tail_level_next = level_word;
            tail_zero_next  = mul_zero_reg;
        end
        else if (push)
        begin
            if (!head_valid_reg)
            begin
                head_valid_next = 1'b1;
                head_level_next = level_word;
                head_zero_next  = mul_zero_reg;
            end
            else
            begin
                tail_valid_next = 1'b1;
                tail_level_next = level_word;
                tail_zero_next  = mul_zero_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_valid_reg <= 1'b0;
            tail_valid_reg <= 1'b0;
        end
        else
        begin
            head_valid_reg <= head_valid_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_level_reg <= head_level_next;
        head_zero_reg  <= head_zero_next;
        tail_level_reg <= tail_level_next;
        tail_zero_reg  <= tail_zero_next;
    end

    assign levels.valid      = head_valid_reg;
    assign levels.level_db   = head_level_reg;
    assign levels.zero_input = head_zero_reg;

    `CMDB_ASSERT_ALWAYS(a_tail_needs_head, clk, !tail_valid_reg || head_valid_reg, "spare word held without head word")
    `CMDB_ASSERT(a_zero_floor, clk, rst_n, levels.valid && levels.zero_input |-> levels.level_db == LEVEL_MIN, "zero word not at floor")
    `CMDB_ASSERT(a_level_range, clk, rst_n, levels.valid |-> levels.level_db <= LEVEL_MAX && levels.level_db >= LEVEL_MIN, "level outside clamp range")

endmodule

/* bench/cmdb_level_checker.sv */
// ----------------------------------------------------------------------------
// cmdb_level_checker
// watches the sample, level and divisor channels of the magnitude-to-dB unit,
// predicts each level word from the accepted sample and the current divisor,
// and compares it field by field with the words that leave the block in order
// ----------------------------------------------------------------------------
module cmdb_level_checker (
    input  logic   clk,
    input  logic   rst_n,
    cmdb_sample_if samples,
    cmdb_level_if  levels,
    cmdb_cfg_if    cfg,
    output int     outstanding,
    output int     mismatches
);
    import cmdb_pkg::*;

    typedef struct packed {
        logic signed [15:0] level_db;
        logic               zero_input;
    } level_word_t;

    // cubic coefficients and 10*log10(2), q24
    localparam longint LOG_C3   = 64'sd20661073;
    localparam longint LOG_C2   = -64'sd69097386;
    localparam longint LOG_C1   = 64'sd101031894;
    localparam longint LOG_C0   = -64'sd52579199;
    localparam longint DB_SCALE = 64'sd50504453;
    localparam longint Q24_ONE  = 64'sd1 <<< 24;
    localparam longint DB_FLOOR = 64'sd25600;

    level_word_t          level_q[$];
    logic [NORM_BITS-1:0] divisor;

    // q24 product rounded half away from zero
    function automatic longint round_mul_q24(input longint a, input longint f);
        longint mag;
        longint prod;
        mag  = (a < 0) ? -a : a;
        prod = (mag * f + (64'sd1 <<< 23)) >>> 24;
        return (a < 0) ? -prod : prod;
    endfunction

    function automatic longint log2_q24(input longint v);
        int     msb;
        longint mant;
        longint y;
        msb = 63;
        while (msb > 0 && v[msb] == 1'b0)
            msb--;
        if (msb + 1 >= 24)
            mant = v >>> (msb + 1 - 24);
        else
            mant = v <<< (24 - msb - 1);
        y = LOG_C3;
        y = round_mul_q24(y, mant) + LOG_C2;
        y = round_mul_q24(y, mant) + LOG_C1;
        y = round_mul_q24(y, mant) + LOG_C0;
        return y + longint'(msb + 1) * Q24_ONE;
    endfunction

    function automatic level_word_t predict_level(input logic signed [15:0] i_val,
                                                  input logic signed [15:0] q_val,
                                                  input logic [NORM_BITS-1:0] n_val);
        longint      ai;
        longint      aq;
        longint      power;
        longint      n_eff;
        longint      diff;
        longint      diff_mag;
        longint      scaled;
        level_word_t w;
        ai    = (i_val < 0) ? -longint'(i_val) : longint'(i_val);
        aq    = (q_val < 0) ? -longint'(q_val) : longint'(q_val);
        power = ai * ai + aq * aq;
        n_eff = (n_val == '0) ? 64'sd1 : longint'({47'd0, n_val});
        if (power == 0) begin
            w.level_db   = 16'(-DB_FLOOR);
            w.zero_input = 1'b1;
        end
        else begin
            diff     = log2_q24(power) - 2 * log2_q24(n_eff);
            diff_mag = (diff < 0) ? -diff : diff;
            scaled   = (diff_mag * DB_SCALE + (64'sd1 <<< 39)) >>> 40;
            if (scaled > DB_FLOOR)
                scaled = DB_FLOOR;
            w.level_db   = 16'((diff < 0) ? -scaled : scaled);
            w.zero_input = 1'b0;
        end
        return w;
    endfunction

    initial mismatches = 0;

    always @(posedge clk or negedge rst_n)
    begin : watch
        level_word_t want;
        if (!rst_n)
        begin
            divisor = 17'd1024;
            level_q.delete();
            outstanding = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
                divisor = cfg.normalize_size;
            if (samples.valid && samples.ready)
                level_q.push_back(predict_level(samples.sample_i, samples.sample_q, divisor));
            if (levels.valid && levels.ready)
            begin
                if (level_q.size() == 0)
                begin
                    $display("%0t: unexpected word, expected none, actual level_db %0d zero_input %0b",
                             $time, levels.level_db, levels.zero_input);
                    mismatches++;
                end
                else
                begin
                    want = level_q.pop_front();
                    if (levels.level_db !== want.level_db)
                    begin
                        $display("%0t: level_db mismatch, expected %0d, actual %0d",
                                 $time, want.level_db, levels.level_db);
                        mismatches++;
                    end
                    if (levels.zero_input !== want.zero_input)
                    begin
                        $display("%0t: zero_input mismatch, expected %0b, actual %0b",
                                 $time, want.zero_input, levels.zero_input);
                        mismatches++;
                    end
                end
            end
            outstanding = level_q.size();
        end
    end

endmodule

/* bench/complex_magnitude_to_db_unit_tb.sv */
// ----------------------------------------------------------------------------
// complex_magnitude_to_db_unit_tb
// drives corner samples and then random samples through the magnitude-to-dB
// unit under a series of divisors, with random gaps on both sides; a checker
// beside the block predicts every level word and counts mismatches
// ----------------------------------------------------------------------------
module complex_magnitude_to_db_unit_tb;
    import cmdb_pkg::*;

    localparam int LATENCY        = 14;
    localparam int DIVISOR_SETTLE = LATENCY + 6;
    localparam int PHASES         = 11;
    localparam int PHASE_WORDS    = 130;

    logic clk;
    logic rst_n;
    int   outstanding;
    int   mismatches;

    // gap state per side: 0 sender, 1 receiver
    int run_left[2] = '{0, 0};
    bit quiet[2]    = '{0, 0};

    int corner_i[16] = '{0, 1, 0, -1, 32767, -32768, 0, 32767,
                         -32768, 32767, -32767, 256, 3, 181, 12345, -21846};
    int corner_q[16] = '{0, 0, -1, -1, 0, 0, -32768, 32767,
                         -32768, -32768, 32767, 0, 4, 181, -23456, 21845};
    int probe_i[3]   = '{1, 0, -32768};
    int probe_q[3]   = '{0, -1, -32768};
    int divisors[6]  = '{131071, 0, 65536, 1, 4096, 1024};

    cmdb_sample_if #(.SAMPLE_BITS(16)) samples_ch ();
    cmdb_level_if  #(.LEVEL_BITS(16))  levels_ch ();
    cmdb_cfg_if    #(.NORM_BITS(NORM_BITS)) cfg_ch ();

    complex_magnitude_to_db_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .levels  (levels_ch),
        .cfg     (cfg_ch)
    );

    cmdb_level_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .samples     (samples_ch),
        .levels      (levels_ch),
        .cfg         (cfg_ch),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #400000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // runs of random gaps, with a run of none drawn one time in four
    function automatic int draw_gap(input int side);
        if (run_left[side] == 0)
        begin
            quiet[side]    = ($urandom_range(0, 3) == 0);
            run_left[side] = $urandom_range(16, 96);
        end
        run_left[side]--;
        return quiet[side] ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic logic signed [15:0] pick_count();
        case ($urandom_range(0, 9))
            0: return 16'sd0;
            1:
            begin
                case ($urandom_range(0, 4))
                    0: return 16'sh8000;
                    1: return 16'sh7fff;
                    2: return 16'sh8001;
                    3: return 16'sd1;
                    default: return -16'sd1;
                endcase
            end
            2, 3: return 16'(int'($urandom_range(0, 16)) - 8);
            4: return $signed(16'($urandom)) >>> $urandom_range(0, 15);
            default: return 16'($urandom);
        endcase
    endfunction

    // entered and left at a falling edge
    task automatic send_sample(input logic signed [15:0] i_val, input logic signed [15:0] q_val);
        int gap;
        gap = draw_gap(0);
        if (gap > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        samples_ch.valid    <= 1'b1;
        samples_ch.sample_i <= i_val;
        samples_ch.sample_q <= q_val;
        do @(posedge clk); while (!samples_ch.ready);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        samples_ch.valid <= 1'b0;
        do @(negedge clk); while (outstanding != 0);
    endtask

    task automatic write_divisor(input logic [NORM_BITS-1:0] value);
        cfg_ch.valid          <= 1'b1;
        cfg_ch.normalize_size <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        // divisor log settles after a write
        repeat (DIVISOR_SETTLE) @(negedge clk);
    endtask

    // receiver stalls
    initial
    begin : drain
        int stall_left;
        stall_left      = 0;
        levels_ch.ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (levels_ch.valid && levels_ch.ready)
                stall_left = draw_gap(1);
            @(negedge clk);
            levels_ch.ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    initial
    begin : stimulus
        logic [NORM_BITS-1:0] n_val;
        rst_n                 = 1'b0;
        samples_ch.valid      = 1'b0;
        samples_ch.sample_i   = '0;
        samples_ch.sample_q   = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.normalize_size = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // corners at the reset divisor
        for (int k = 0; k < 16; k++)
            send_sample(16'(corner_i[k]), 16'(corner_q[k]));

        for (int s = 0; s < PHASES; s++)
        begin
            if (s < 6)
                n_val = 17'(divisors[s]);
            else if (s % 2 == 1)
                n_val = 17'($urandom_range(1, 65536));
            else
                n_val = 17'($urandom_range(0, 131071));
            wait_idle();
            write_divisor(n_val);
            for (int k = 0; k < PHASE_WORDS; k++)
            begin
                if (s == 4 && k == PHASE_WORDS / 2)
                    wait_idle();
                // floor clamp at the largest divisor, zero divisor as one
                if (s < 2 && k < 3)
                    send_sample(16'(probe_i[k]), 16'(probe_q[k]));
                else
                    send_sample(pick_count(), pick_count());
            end
        end

        wait_idle();
        repeat (LATENCY + 16) @(negedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
